// File: design/rti_pkg.sv
`timescale 1ns / 1ps
package rti_pkg;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    vec_t v0;
    vec_t v1;
    vec_t v2;
  } tri_t;

  typedef struct packed {
    vec_t origin;
    vec_t dir;
  } ray_t;

  // triple products in 2^-24 units
  typedef struct packed {
    logic signed [53:0] det;
    logic signed [53:0] un;
    logic signed [53:0] vn;
    logic signed [53:0] tn;
  } sums_t;

  // long division state for t, u and v
  typedef struct packed {
    logic        hit;
    logic        tneg;
    logic        tsat;
    logic [53:0] den;
    logic [53:0] rt;
    logic [53:0] ru;
    logic [53:0] rv;
    logic [31:0] xt;
    logic [31:0] qt;
    logic [17:0] xu;
    logic [17:0] xv;
    logic [17:0] qu;
    logic [17:0] qv;
  } div_t;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_EPSILON  = 3'd6;

endpackage

// File: design/ray_triangle_intersect_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake                     payload
// triangle  in         start & !busy                 vertex0_x .. vertex2_z
// result    out        done, one cycle, no stall     hit, hit_distance, bary_u, bary_v
// config    in         write_enable                  reg_index, write_data
//
// one triangle accepted every cycle; busy is always low
// the result passes through 4 geometry stages, 3 classify
// stages, 32 long division stages (one quotient bit each), 1 output stage
// rst clears the valid bits and loads the register defaults
// results cannot be held off, so the pipeline never stalls
module ray_triangle_intersect_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  vertex0_x,
  input  logic signed [15:0]  vertex0_y,
  input  logic signed [15:0]  vertex0_z,
  input  logic signed [15:0]  vertex1_x,
  input  logic signed [15:0]  vertex1_y,
  input  logic signed [15:0]  vertex1_z,
  input  logic signed [15:0]  vertex2_x,
  input  logic signed [15:0]  vertex2_y,
  input  logic signed [15:0]  vertex2_z,
  input  logic                write_enable,
  input  logic [2:0]          reg_index,
  input  logic [19:0]         write_data,
  output logic                done,
  output logic                hit,
  output logic signed [31:0]  hit_distance,
  output logic [16:0]         bary_u,
  output logic [16:0]         bary_v
);
  import rti_pkg::*;

  localparam int LATENCY = 40;

  ray_t        ray;
  logic [19:0] epsilon;
  tri_t        tri_in;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray.origin.x <= 16'sd0;
      ray.origin.y <= 16'sd0;
      ray.origin.z <= 16'sd0;
      ray.dir.x    <= 16'sd0;
      ray.dir.y    <= 16'sd0;
      ray.dir.z    <= 16'sd256;
      epsilon      <= 20'd1678;
    end else if (write_enable) begin
      case (reg_index)
        REG_ORIGIN_X: ray.origin.x <= write_data[15:0];
        REG_ORIGIN_Y: ray.origin.y <= write_data[15:0];
        REG_ORIGIN_Z: ray.origin.z <= write_data[15:0];
        REG_DIR_X:    ray.dir.x    <= write_data[15:0];
        REG_DIR_Y:    ray.dir.y    <= write_data[15:0];
        REG_DIR_Z:    ray.dir.z    <= write_data[15:0];
        REG_EPSILON:  epsilon      <= write_data;
        default: begin
        end
      endcase
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign tri_in.v0.x = vertex0_x;
  assign tri_in.v0.y = vertex0_y;
  assign tri_in.v0.z = vertex0_z;
  assign tri_in.v1.x = vertex1_x;
  assign tri_in.v1.y = vertex1_y;
  assign tri_in.v1.z = vertex1_z;
  assign tri_in.v2.x = vertex2_x;
  assign tri_in.v2.y = vertex2_y;
  assign tri_in.v2.z = vertex2_z;

  logic  geom_valid, cls_valid, div_valid;
  sums_t sums;
  div_t  cls_out, div_out;

  rti_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .tri_in    (tri_in),
    .ray       (ray),
    .out_valid (geom_valid),
    .sums      (sums)
  );

  rti_cls u_cls (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (geom_valid),
    .sums      (sums),
    .epsilon   (epsilon),
    .out_valid (cls_valid),
    .dv        (cls_out)
  );

  rti_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cls_valid),
    .d_in      (cls_out),
    .out_valid (div_valid),
    .d_out     (div_out)
  );

  // round half up, then saturate
  logic [32:0] t_inc;
  logic [31:0] t_mag;
  logic [18:0] u_inc, v_inc;
  logic signed [31:0] dist_next;

  assign t_inc = {1'b0, div_out.qt} + 33'd1;
  assign t_mag = t_inc[32:1];
  assign u_inc = {1'b0, div_out.qu} + 19'd1;
  assign v_inc = {1'b0, div_out.qv} + 19'd1;

  always_comb begin
    if (div_out.tneg) begin
      dist_next = (div_out.tsat || t_mag[31]) ? 32'sh8000_0000 : -$signed(t_mag);
    end else begin
      dist_next = (div_out.tsat || t_mag[31]) ? 32'sh7FFF_FFFF : $signed(t_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit          <= div_out.hit;
    hit_distance <= div_out.hit ? dist_next : 32'sd0;
    bary_u       <= div_out.hit ? u_inc[17:1] : 17'd0;
    bary_v       <= div_out.hit ? v_inc[17:1] : 17'd0;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("item result missing after pipeline latency");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> hit_distance == 32'sd0 && bary_u == 17'd0 && bary_v == 17'd0)
    else $error("miss result carries nonzero fields");

  a_bary_range: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> bary_u <= 17'd65536 && bary_v <= 17'd65536)
    else $error("barycentric out of range");

endmodule

// File: design/rti_geom.sv
`timescale 1ns / 1ps
module rti_geom (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rti_pkg::tri_t tri_in,
  input  rti_pkg::ray_t ray,
  output logic          out_valid,
  output rti_pkg::sums_t sums
);
  import rti_pkg::*;

  logic signed [15:0] v0 [3];
  logic signed [15:0] v1 [3];
  logic signed [15:0] v2 [3];
  logic signed [15:0] org [3];
  logic signed [15:0] dir [3];

  always_comb begin
    v0[0] = tri_in.v0.x; v0[1] = tri_in.v0.y; v0[2] = tri_in.v0.z;
    v1[0] = tri_in.v1.x; v1[1] = tri_in.v1.y; v1[2] = tri_in.v1.z;
    v2[0] = tri_in.v2.x; v2[1] = tri_in.v2.y; v2[2] = tri_in.v2.z;
    org[0] = ray.origin.x; org[1] = ray.origin.y; org[2] = ray.origin.z;
    dir[0] = ray.dir.x; dir[1] = ray.dir.y; dir[2] = ray.dir.z;
  end

  logic va, vb, vc, vd;
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [16:0] s [3];
  logic signed [16:0] e1b [3];
  logic signed [16:0] e2b [3];
  logic signed [16:0] sb [3];
  logic signed [33:0] p [3];
  logic signed [34:0] q [3];
  logic signed [50:0] pe [3];
  logic signed [50:0] ps [3];
  logic signed [50:0] pd [3];
  logic signed [51:0] pq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_axis
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      // edges and origin offset
      always_ff @(posedge clk) begin
        e1[i] <= 17'(v1[i]) - 17'(v0[i]);
        e2[i] <= 17'(v2[i]) - 17'(v0[i]);
        s[i]  <= 17'(org[i]) - 17'(v0[i]);
      end

      // p = dir x e2, q = s x e1
      always_ff @(posedge clk) begin
        p[i]   <= 34'(dir[J]) * 34'(e2[K]) - 34'(dir[K]) * 34'(e2[J]);
        q[i]   <= 35'(s[J]) * 35'(e1[K]) - 35'(s[K]) * 35'(e1[J]);
        e1b[i] <= e1[i];
        e2b[i] <= e2[i];
        sb[i]  <= s[i];
      end

      // dot product terms
      always_ff @(posedge clk) begin
        pe[i] <= 51'(e1b[i]) * 51'(p[i]);
        ps[i] <= 51'(sb[i]) * 51'(p[i]);
        pd[i] <= 51'(dir[i]) * 51'(q[i]);
        pq[i] <= 52'(e2b[i]) * 52'(q[i]);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    sums.det <= 54'(pe[0]) + 54'(pe[1]) + 54'(pe[2]);
    sums.un  <= 54'(ps[0]) + 54'(ps[1]) + 54'(ps[2]);
    sums.vn  <= 54'(pd[0]) + 54'(pd[1]) + 54'(pd[2]);
    sums.tn  <= 54'(pq[0]) + 54'(pq[1]) + 54'(pq[2]);
  end

  assign out_valid = vd;

endmodule

// File: design/rti_cls.sv
`timescale 1ns / 1ps
module rti_cls (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rti_pkg::sums_t sums,
  input  logic [19:0]    epsilon,
  output logic           out_valid,
  output rti_pkg::div_t  dv
);
  import rti_pkg::*;

  logic ve, vf, vg;
  logic signed [53:0] det_e, un_e, vn_e, tn_e;
  logic        hit_f, tneg_f;
  logic [53:0] den_f, un_f, vn_f, tmag_f;
  logic        neg;
  logic signed [54:0] uv_sum;
  logic        det_ok, u_ok, v_ok;
  logic        tsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
    end else begin
      ve <= in_valid;
      vf <= ve;
      vg <= vf;
    end
  end

  // two-sided: fold a non-positive determinant
  assign neg = (sums.det <= 54'sd0);

  always_ff @(posedge clk) begin
    det_e <= neg ? -sums.det : sums.det;
    un_e  <= neg ? -sums.un  : sums.un;
    vn_e  <= neg ? -sums.vn  : sums.vn;
    tn_e  <= neg ? -sums.tn  : sums.tn;
  end

  assign uv_sum = 55'(un_e) + 55'(vn_e);
  assign det_ok = (det_e != 54'sd0) && ($unsigned(det_e) >= 54'(epsilon));
  assign u_ok   = !un_e[53] && (un_e <= det_e);
  assign v_ok   = !vn_e[53] && (uv_sum <= 55'(det_e));

  always_ff @(posedge clk) begin
    hit_f  <= det_ok && u_ok && v_ok;
    tneg_f <= tn_e[53];
    den_f  <= $unsigned(det_e);
    un_f   <= $unsigned(un_e);
    vn_f   <= $unsigned(vn_e);
    tmag_f <= tn_e[53] ? $unsigned(-tn_e) : $unsigned(tn_e);
  end

  // quotient of 2^31 or more saturates
  assign tsat = {15'd0, tmag_f} >= {den_f, 15'd0};

  always_ff @(posedge clk) begin
    dv.hit  <= hit_f;
    dv.tneg <= tneg_f;
    dv.tsat <= tsat;
    dv.den  <= den_f;
    dv.rt   <= {15'd0, tmag_f[53:15]};
    dv.xt   <= {tmag_f[14:0], 17'd0};
    dv.qt   <= '0;
    dv.ru   <= {1'b0, un_f[53:1]};
    dv.xu   <= {un_f[0], 17'd0};
    dv.qu   <= '0;
    dv.rv   <= {1'b0, vn_f[53:1]};
    dv.xv   <= {vn_f[0], 17'd0};
    dv.qv   <= '0;
  end

  assign out_valid = vg;

endmodule

// File: design/rti_div.sv
`timescale 1ns / 1ps
module rti_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rti_pkg::div_t d_in,
  output logic          out_valid,
  output rti_pkg::div_t d_out
);
  import rti_pkg::*;

  localparam int STAGES = 32;
  localparam int UV_START = 14;

  // one restoring step: {quotient bit, next remainder}
  function automatic logic [54:0] step(logic [53:0] r, logic b, logic [53:0] den);
    logic [54:0] r2;
    logic        ge;
    logic [54:0] diff;
    r2   = {r, b};
    ge   = r2 >= {1'b0, den};
    diff = r2 - {1'b0, den};
    return ge ? {1'b1, diff[53:0]} : {1'b0, r2[53:0]};
  endfunction

  div_t st [STAGES + 1];
  logic vs [STAGES + 1];

  assign st[0] = d_in;
  assign vs[0] = in_valid;

  genvar k;
  generate
    for (k = 0; k < STAGES; k++) begin : g_step
      div_t        nx;
      logic [54:0] rt_s, ru_s, rv_s;

      always_comb begin
        nx   = st[k];
        rt_s = step(st[k].rt, st[k].xt[31], st[k].den);
        ru_s = step(st[k].ru, st[k].xu[17], st[k].den);
        rv_s = step(st[k].rv, st[k].xv[17], st[k].den);
        nx.rt = rt_s[53:0];
        nx.xt = {st[k].xt[30:0], 1'b0};
        nx.qt = {st[k].qt[30:0], rt_s[54]};
        if (k >= UV_START) begin
          nx.ru = ru_s[53:0];
          nx.xu = {st[k].xu[16:0], 1'b0};
          nx.qu = {st[k].qu[16:0], ru_s[54]};
          nx.rv = rv_s[53:0];
          nx.xv = {st[k].xv[16:0], 1'b0};
          nx.qv = {st[k].qv[16:0], rv_s[54]};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vs[k + 1] <= 1'b0;
        end else begin
          vs[k + 1] <= vs[k];
        end
      end

      always_ff @(posedge clk) begin
        st[k + 1] <= nx;
      end
    end
  endgenerate

  assign out_valid = vs[STAGES];
  assign d_out     = st[STAGES];

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rti_pkg::*;

  localparam int LATENCY = 40;

  typedef struct {
    logic        hit;
    logic [31:0] t_q;
    logic [16:0] u;
    logic [16:0] v;
  } isect_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  coord_t vertex0_x, vertex0_y, vertex0_z;
  coord_t vertex1_x, vertex1_y, vertex1_z;
  coord_t vertex2_x, vertex2_y, vertex2_z;
  logic write_enable;
  logic [2:0] reg_index;
  logic [19:0] write_data;
  logic done;
  logic hit;
  logic signed [31:0] hit_distance;
  logic [16:0] bary_u;
  logic [16:0] bary_v;

  ray_triangle_intersect_unit uut (.*);

  longint org_m[3];
  longint dir_m[3];
  longint eps_m;
  isect_t pending_hits[$];
  int errors;
  int burst_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

  // long division to Q.16, round half up, integer part capped
  function automatic longint unsigned frac_q16(longint unsigned num, longint unsigned den);
    longint unsigned q, r, f;
    q = num / den;
    r = num % den;
    f = 0;
    if (q > 65536) return longint'(65537) << 16;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= den) begin
        r = r - den;
        f = f | 1;
      end
    end
    f = f + (q << 16);
    if (r >= den - r) f = f + 1;
    return f;
  endfunction

  function automatic isect_t trace(coord_t c[9]);
    isect_t res;
    longint p0[3], e1[3], e2[3], pv[3], sv[3], qv[3];
    longint det, un, vn, tn;
    longint unsigned mag;
    res = '{0, 0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      p0[i] = c[i];
      e1[i] = longint'(c[3+i]) - p0[i];
      e2[i] = longint'(c[6+i]) - p0[i];
    end
    pv[0] = dir_m[1]*e2[2] - dir_m[2]*e2[1];
    pv[1] = dir_m[2]*e2[0] - dir_m[0]*e2[2];
    pv[2] = dir_m[0]*e2[1] - dir_m[1]*e2[0];
    det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
    for (int i = 0; i < 3; i++) sv[i] = (det > 0) ? org_m[i] - p0[i] : p0[i] - org_m[i];
    if (det <= 0) det = -det;
    if (det == 0 || det < eps_m) return res;
    un = sv[0]*pv[0] + sv[1]*pv[1] + sv[2]*pv[2];
    if (un < 0 || un > det) return res;
    qv[0] = sv[1]*e1[2] - sv[2]*e1[1];
    qv[1] = sv[2]*e1[0] - sv[0]*e1[2];
    qv[2] = sv[0]*e1[1] - sv[1]*e1[0];
    vn = dir_m[0]*qv[0] + dir_m[1]*qv[1] + dir_m[2]*qv[2];
    if (vn < 0 || un + vn > det) return res;
    tn = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
    if (tn >= 0) begin
      mag = frac_q16(tn, det);
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      res.t_q = mag[31:0];
    end else begin
      mag = frac_q16(-tn, det);
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      res.t_q = 32'(0 - mag);
    end
    res.hit = 1;
    mag = frac_q16(un, det);
    res.u = mag[16:0];
    mag = frac_q16(vn, det);
    res.v = mag[16:0];
    return res;
  endfunction

  task automatic send_triangle(coord_t c[9]);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    {vertex0_x, vertex0_y, vertex0_z} <= {c[0], c[1], c[2]};
    {vertex1_x, vertex1_y, vertex1_z} <= {c[3], c[4], c[5]};
    {vertex2_x, vertex2_y, vertex2_z} <= {c[6], c[7], c[8]};
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hits.push_back(trace(c));
  endtask

  task automatic drain();
    start <= 0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    write_enable <= 1;
    reg_index <= idx;
    write_data <= val;
    @(posedge clk);
    if (idx < REG_EPSILON) begin
      if (idx < REG_DIR_X) org_m[idx] = coord_t'(val[15:0]);
      else dir_m[idx - REG_DIR_X] = coord_t'(val[15:0]);
    end else if (idx == REG_EPSILON) eps_m = val;
  endtask

  task automatic set_ray(coord_t o[3], coord_t d[3], logic [19:0] eps);
    drain();
    write_reg(REG_ORIGIN_X, 20'(o[0]));
    write_reg(REG_ORIGIN_Y, 20'(o[1]));
    write_reg(REG_ORIGIN_Z, 20'(o[2]));
    write_reg(REG_DIR_X, 20'(d[0]));
    write_reg(REG_DIR_Y, 20'(d[1]));
    write_reg(REG_DIR_Z, 20'(d[2]));
    write_reg(REG_EPSILON, eps);
    write_reg(3'd7, 20'hFFFFF);
    write_enable <= 0;
  endtask

  function automatic coord_t rnd_coord(int span);
    return coord_t'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  // mode 0: triangle around a point on the ray, mostly hits; mode 1: random; else extreme coordinates
  task automatic send_near(int span, int mode);
    coord_t c[9];
    longint hp;
    int k;
    k = $urandom_range(0, 4);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0: begin
          hp = org_m[i%3] + ((dir_m[i%3] * k) >>> 8) * 64;
          c[i] = coord_t'(hp + rnd_coord(span));
        end
        1: c[i] = coord_t'($urandom);
        default: c[i] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      endcase
    end
    send_triangle(c);
  endtask

  always @(posedge clk) begin
    if (done) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b t=%0h", $time, hit, hit_distance);
        errors++;
      end else begin
        isect_t e;
        e = pending_hits.pop_front();
        if (hit !== e.hit || hit_distance !== e.t_q || bary_u !== e.u || bary_v !== e.v) begin
          $display("%0t: expected hit=%0b t=%0h u=%0h v=%0h, got hit=%0b t=%0h u=%0h v=%0h",
                   $time, e.hit, e.t_q, e.u, e.v, hit, hit_distance, bary_u, bary_v);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_ray();
    coord_t c[9];
    c = '{-256, -256, 512, 256, -256, 512, 0, 256, 512};
    send_triangle(c);
    c = '{-256, -256, 512, 0, 256, 512, 256, -256, 512};
    send_triangle(c);
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(c);
    c = '{256, 256, 0, 512, 256, 0, 256, 512, 0};
    send_triangle(c);
    c = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
          0, 16'sh7FFF, 16'sh8000};
    send_triangle(c);
    c = '{0, 0, 256, 256, 0, 256, 0, 256, 256};
    send_triangle(c);
    c = '{0, 0, -256, 1, 0, -256, 0, 1, -256};
    send_triangle(c);
  endtask

  task automatic test_extremes();
    coord_t o[3], d[3];
    o = '{16'sh8000, 16'sh7FFF, 16'sh8000};
    d = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
    set_ray(o, d, 20'hFFFFF);
    repeat (6) send_near(64, 2);
    o = '{0, 0, 0};
    d = '{0, 0, 16'sh7FFF};
    set_ray(o, d, 0);
    for (int i = 0; i < 6; i++) send_near(i * 500, 0);
  endtask

  task automatic test_random();
    coord_t o[3], d[3];
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = (ph < 6) ? rnd_coord(2000) : coord_t'($urandom);
        d[i] = (ph < 6) ? rnd_coord(512) : coord_t'($urandom);
      end
      set_ray(o, d, (ph % 3 == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000)));
      for (int n = 0; n < 140; n++)
        send_near((n % 4 == 0) ? 4000 : 300, (n % 7 == 0) ? 1 : 0);
    end
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    rst = 1;
    start = 0;
    write_enable = 0;
    reg_index = 0;
    write_data = 0;
    {vertex0_x, vertex0_y, vertex0_z} = 0;
    {vertex1_x, vertex1_y, vertex1_z} = 0;
    {vertex2_x, vertex2_y, vertex2_z} = 0;
    org_m = '{0, 0, 0};
    dir_m = '{0, 0, 256};
    eps_m = 1678;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_ray();
    test_extremes();
    test_random();
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
design/rti_pkg.sv
design/rti_geom.sv
design/rti_cls.sv
design/rti_div.sv
design/ray_triangle_intersect_unit.sv
test/testbench.sv
